// ----- src/hvc_pkg.sv -----
// Shared types, constants and codes for the hashed visit-count novelty block.
package hvc_pkg;

	localparam int CAPACITY = 64;
	localparam int MAX_DIM  = 256;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DIM_W = $clog2(MAX_DIM + 1);

	localparam logic [31:0] HASH_SEED = 32'd5381;
	localparam logic [13:0] SCALE     = 14'd10000;
	localparam logic [15:0] VISIT_MAX = 16'hFFFF;

	localparam logic [1:0] REG_THRESHOLD     = 2'd0;
	localparam logic [1:0] REG_DEFAULT_COUNT = 2'd1;
	localparam logic [1:0] REG_ENTRIES       = 2'd2;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_HIT    = 2'd0,
		ST_INSERT = 2'd1,
		ST_FULL   = 2'd2,
		ST_QMISS  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_DECIDE,
		S_ROOT,
		S_OUT
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [31:0]      hash;
		logic [DIM_W-1:0] dim;
	} job_t;

	typedef struct packed {
		logic [31:0]      hash;
		logic [DIM_W-1:0] dim;
		logic [15:0]      visits;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [16:0] threshold;
		logic [15:0] default_count;
		logic [6:0]  entries_in_use;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [16:0] seen_count;
		logic [16:0] novelty;
		logic        is_novel;
		logic [31:0] novel_total;
		logic [31:0] recorded_total;
	} result_t;

endpackage

// ----- src/hvc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/hvc_fifo.sv -----
// Two-entry job queue between the hashing front and the table back end.
module hvc_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  hvc_pkg::job_t push_job,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output hvc_pkg::job_t pop_job
);
	import hvc_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/hvc_front.sv -----
// Front end: takes samples, scales and folds them into the running hash.
module hvc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,
	input  logic [1:0]    s_tuser,
	input  logic          s_tlast,
	output logic          push,
	output hvc_pkg::job_t push_job,
	input  logic          full
);
	import hvc_pkg::*;

	logic [31:0]      hash_q;
	logic [DIM_W-1:0] dim_q;

	op_t              op;
	logic             accept;
	logic             neg;
	logic [31:0]      mag;
	logic [45:0]      prod;
	logic [31:0]      q;
	logic [31:0]      v;
	logic [31:0]      hash_next;
	logic [DIM_W-1:0] dim_next;

	assign s_tready = !full;
	assign accept   = s_tvalid && !full;
	assign op       = op_t'(s_tuser);

	always_comb begin
		neg       = s_tdata[31];
		mag       = neg ? (~s_tdata + 32'd1) : s_tdata;
		prod      = 46'(mag) * 46'(SCALE);
		q         = 32'(prod[45:16]);
		v         = neg ? (~q + 32'd1) : q;
		hash_next = (hash_q << 5) + hash_q + v;
		dim_next  = (dim_q < DIM_W'(MAX_DIM)) ? dim_q + DIM_W'(1) : dim_q;
	end

	always_comb begin
		push          = 1'b0;
		push_job.op   = op;
		push_job.hash = hash_next;
		push_job.dim  = dim_next;
		case (op)
			OP_CLEAR:           push = accept;
			OP_RECORD, OP_QUERY: push = accept && s_tlast;
			default:            push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
			dim_q  <= '0;
		end else if (accept) begin
			case (op)
				OP_RECORD, OP_QUERY: begin
					if (s_tlast) begin
						hash_q <= HASH_SEED;
						dim_q  <= '0;
					end else begin
						hash_q <= hash_next;
						dim_q  <= dim_next;
					end
				end
				OP_CLEAR: begin
					hash_q <= HASH_SEED;
					dim_q  <= '0;
				end
				default: begin
					hash_q <= hash_q;
				end
			endcase
		end
	end

endmodule

// ----- src/hvc_back.sv -----
// Back end: table search and update, novelty root, totals and result register.
module hvc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  hvc_pkg::job_t    q_job,
	output logic             q_pop,
	input  hvc_pkg::cfg_t    cfg,
	output logic             m_tvalid,
	input  logic             m_tready,
	output hvc_pkg::result_t res
);
	import hvc_pkg::*;

	typedef logic [ENTRY_W-1:0] ram_wdata_t;

	state_t           state_q, state_d;
	job_t             job_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] filled_q;
	logic             hit_q;
	status_t          status_q;
	logic [16:0]      cnt_q;
	logic [16:0]      nov_q;
	logic [33:0]      sq_q;
	logic [4:0]       bit_q;
	logic [31:0]      novel_total_q;
	logic [31:0]      rec_total_q;
	result_t          res_q;

	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	entry_t             rd_entry, wr_entry;

	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] idx_inc;
	logic             match;
	logic [15:0]      vis_inc;
	status_t          dec_status;
	logic [16:0]      dec_count;

	logic [16:0] cand, nov_fin;
	logic [33:0] cand_sq;
	logic [16:0] d;
	logic [50:0] prod;
	logic        take, novel;

	hvc_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);
	assign m_tvalid = (state_q == S_OUT);
	assign res      = res_q;

	always_comb begin
		limit   = (32'(cfg.entries_in_use) > CAPACITY) ? CNT_W'(CAPACITY)
		                                               : CNT_W'(cfg.entries_in_use);
		idx_inc = idx_q + CNT_W'(1);
		match   = (rd_entry.hash == job_q.hash) && (rd_entry.dim == job_q.dim);
		vis_inc = (rd_entry.visits == VISIT_MAX) ? rd_entry.visits
		                                         : rd_entry.visits + 16'd1;
		dec_status = ST_QMISS;
		dec_count  = 17'(cfg.default_count);
		if (job_q.op == OP_RECORD) begin
			if (hit_q) begin
				dec_status = ST_HIT;
				dec_count  = 17'(vis_inc);
			end else if (filled_q < limit) begin
				dec_status = ST_INSERT;
				dec_count  = 17'd1;
			end else begin
				dec_status = ST_FULL;
			end
		end else if (hit_q) begin
			dec_status = ST_HIT;
			dec_count  = 17'(rd_entry.visits) + 17'd1;
		end
	end

	// one result bit per step: largest n with n*n*(count+1) <= 2^32
	always_comb begin
		d       = cnt_q + 17'd1;
		cand    = nov_q | (17'd1 << bit_q);
		cand_sq = sq_q + (34'(nov_q) << ({1'b0, bit_q} + 6'd1))
		        + (34'd1 << {bit_q, 1'b0});
		prod    = 51'(cand_sq) * 51'(d);
		take    = (prod <= 51'h1_0000_0000);
		nov_fin = take ? cand : nov_q;
		novel   = (nov_fin > cfg.threshold);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (!q_empty && q_job.op != OP_CLEAR) begin
					state_d = (filled_q == '0) ? S_DECIDE : S_READ;
				end
			end
			S_READ:   state_d = S_CMP;
			S_CMP: begin
				if (match || idx_inc == filled_q) state_d = S_DECIDE;
				else                              state_d = S_READ;
			end
			S_DECIDE: state_d = S_ROOT;
			S_ROOT:   if (bit_q == 5'd0) state_d = S_OUT;
			S_OUT:    if (m_tready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = idx_q[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		wr_entry.hash   = job_q.hash;
		wr_entry.dim    = job_q.dim;
		wr_entry.visits = 16'd1;
		case (state_q)
			S_IDLE: q_pop  = !q_empty;
			S_READ: ram_re = 1'b1;
			S_DECIDE: begin
				if (dec_status == ST_HIT && job_q.op == OP_RECORD) begin
					ram_we          = 1'b1;
					wr_entry.visits = vis_inc;
				end else if (dec_status == ST_INSERT) begin
					ram_we    = 1'b1;
					ram_waddr = filled_q[IDX_W-1:0];
				end
			end
			default: q_pop = 1'b0;
		endcase
		ram_wdata = ram_wdata_t'(wr_entry);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				job_q <= q_job;
				idx_q <= '0;
				hit_q <= 1'b0;
			end
			S_CMP: begin
				hit_q <= match;
				if (!match) idx_q <= idx_inc;
			end
			S_DECIDE: begin
				status_q <= dec_status;
				cnt_q    <= dec_count;
				nov_q    <= '0;
				sq_q     <= '0;
				bit_q    <= 5'd16;
			end
			S_ROOT: begin
				if (take) begin
					nov_q <= cand;
					sq_q  <= cand_sq;
				end
				bit_q <= bit_q - 5'd1;
			end
			default: begin
				bit_q <= bit_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			filled_q      <= '0;
			novel_total_q <= '0;
			rec_total_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && !q_empty && q_job.op == OP_CLEAR) begin
				filled_q      <= '0;
				novel_total_q <= '0;
				rec_total_q   <= '0;
			end
			if (state_q == S_DECIDE) begin
				if (dec_status == ST_INSERT) filled_q <= filled_q + CNT_W'(1);
				if (job_q.op == OP_RECORD) rec_total_q <= rec_total_q + 32'd1;
			end
			if (state_q == S_ROOT && bit_q == 5'd0 && novel) begin
				novel_total_q <= novel_total_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ROOT && bit_q == 5'd0) begin
			res_q.status         <= status_q;
			res_q.seen_count     <= cnt_q;
			res_q.novelty        <= nov_fin;
			res_q.is_novel       <= novel;
			res_q.novel_total    <= novel_total_q + (novel ? 32'd1 : 32'd0);
			res_q.recorded_total <= rec_total_q;
		end
	end

endmodule

// ----- src/hashed_visit_count_novelty.sv -----
// Top level of the hashed visit-count novelty block: config registers and the two halves.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------------
//  s_*      | in  | s_tvalid / s_tready | tdata sample, tuser opcode, tlast end
//  m_*      | out | m_tvalid / m_tready | tuser status, tdata counts/novelty/totals
//  cfg_*    | in  | cfg_we (no wait)    | cfg_index register, cfg_data value
//
// Samples are hashed one per cycle in the front end (scale multiply plus the
// times-33 fold). A vector end or clear is queued as a request for the back end.
// A clear empties the table and zeroes the totals; other requests search the
// table serially (RAM read, then compare, per filled entry), update it on a
// record, then run a 17-step bitwise reciprocal root. The front keeps taking
// samples while the queue (two requests) has room; s_tready drops when it is full.
// A result waits in the output register until m_tready; the back end holds until
// then. Reset clears control state and the totals; table contents are not cleared.
module hashed_visit_count_novelty (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] sample
	input  logic [1:0]   s_tuser,   // [1:0] opcode
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // seen_count, novelty, is_novel, novel_total,
	                                // recorded_total, zero pad
	output logic [1:0]   m_tuser,   // [1:0] status
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [16:0]  cfg_data
);
	import hvc_pkg::*;

	cfg_t    cfg_q;
	logic    push, full, pop, empty;
	job_t    push_job, pop_job;
	result_t res;

	// register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold      <= 17'd32768;
			cfg_q.default_count  <= 16'd1;
			cfg_q.entries_in_use <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:     cfg_q.threshold      <= cfg_data;
				REG_DEFAULT_COUNT: cfg_q.default_count  <= cfg_data[15:0];
				REG_ENTRIES:       cfg_q.entries_in_use <= cfg_data[6:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	hvc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.push     (push),
		.push_job (push_job),
		.full     (full)
	);

	hvc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.pop_job  (pop_job)
	);

	hvc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (empty),
		.q_job    (pop_job),
		.q_pop    (pop),
		.cfg      (cfg_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {5'd0, res.recorded_total, res.novel_total, res.is_novel,
	                  res.novelty, res.seen_count};

endmodule

// ----- src/hvc_checker.sv -----
// Port-level checks on the result stream, bound to the top level.
module hvc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic [1:0]   m_tuser
);
	import hvc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_INSERT |->
			m_tdata[16:0] == 17'd1 && m_tdata[33:17] == 17'd46340)
		else $error("insert result without count one");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] == 17'd0) == (m_tdata[33:17] == 17'd65536))
		else $error("full novelty not tied to zero count");

	a_novel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> m_tdata[33:17] != 17'd0 && m_tdata[66:35] != 32'd0)
		else $error("novel flag with zero novelty or total");

endmodule

bind hashed_visit_count_novelty hvc_checker u_hvc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
